// ===== hw/rtl/sac_pkg.sv =====
// Shared types and constants for the aligned stack allocator.
// Used by every module of the block but sac_ram; depends on nothing.
package sac_pkg;

    // Header reserved in front of each block, and log2 of it.
    localparam int HEADER_BYTES = 8;
    localparam int HDR_SHIFT    = 3;

    // Default arena capacity in bytes.
    localparam int ARENA_BYTES_DEF = 65536;

    // Widths fixed by the field definitions.
    localparam int TOP_W   = 17;
    localparam int SIZE_W  = 17;
    localparam int ALIGN_W = 13;
    localparam int ADDR_W  = 32;
    localparam int CFG_W   = 32;

    // Operation codes.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ALIGN = 2'd1;
    localparam logic [1:0] ST_SIZE  = 2'd2;
    localparam logic [1:0] ST_ROOM  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    // One request beat.
    typedef struct packed {
        logic [1:0]         mode;
        logic [SIZE_W-1:0]  req_size;
        logic [ALIGN_W-1:0] req_align;
        logic [ADDR_W-1:0]  free_address;
    } req_t;

    // One response beat.
    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] data_address;
        logic [TOP_W-1:0]  top_after;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic finish;
    } ctrl_t;

endpackage

// ===== hw/rtl/sac_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module sac_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sac_ctrl.sv =====
// Controller of the aligned stack allocator: accept and finish sequencing.
// Depends on sac_pkg for the command struct.
module sac_ctrl
    import sac_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output logic  done,
    output ctrl_t ctrl
);

    typedef enum logic {
        S_IDLE,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // Accept a request in idle, finish it in the following cycle.
    always_comb
    begin
        ctrl.load   = 1'b0;
        ctrl.finish = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ctrl.finish = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        done_next = ctrl.finish;
    end

    // State and the response strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_FIN);
    assign done = done_reg;

endmodule

// ===== hw/rtl/sac_datapath.sv =====
// Datapath of the aligned stack allocator: configuration, top offset,
// address arithmetic and the header store. Depends on sac_pkg and sac_ram.
module sac_datapath
    import sac_pkg::*;
#(
    parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    input  req_t             req,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output rsp_t             rsp
);

    localparam int HDR_DEPTH = ARENA_BYTES / HEADER_BYTES;
    localparam int IW        = $clog2(HDR_DEPTH);
    localparam int HW        = IW + HDR_SHIFT;
    localparam logic [31:0] ARENA_L  = 32'(ARENA_BYTES);
    localparam logic [32:0] ARENA_33 = 33'(ARENA_BYTES);
    localparam logic [32:0] HDR_33   = 33'(HEADER_BYTES);

    // Configuration and allocator state.
    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] arena_reg;
    logic [TOP_W-1:0]  top_reg;
    logic [TOP_W-1:0]  top_next;

    // Item registers filled on accept.
    logic [1:0]         mode_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               align_bad_reg;
    logic [32:0]        unal_reg;
    logic [ALIGN_W-1:0] pad_reg;
    logic               top_over_reg;
    logic [TOP_W-1:0]   room_left_reg;
    logic               free_ok_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    // First-stage arithmetic, from the request beat.
    logic [TOP_W-1:0]   lim;
    logic               align_bad;
    logic [ALIGN_W-1:0] eff_mask;
    logic [32:0]        unal;
    logic [ALIGN_W-1:0] pad;
    logic [32:0]        lo;
    logic [32:0]        addr_ext;
    logic [32:0]        hoff;
    logic               free_ok;

    // Second-stage arithmetic.
    logic [32:0]       data_addr;
    logic [17:0]       total;
    logic              room_bad;
    logic [1:0]        alloc_status;
    logic [HW-1:0]     hdr_off;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [IW-1:0]     ram_raddr;
    logic [TOP_W-1:0]  ram_rdata;

    // Usable arena is the smaller of the register and the capacity.
    assign lim = ({15'd0, arena_reg} < ARENA_L) ? arena_reg : ARENA_L[TOP_W-1:0];

    // Alignment must be a nonzero power of two.
    assign align_bad = (req.req_align == '0) ||
                       ((req.req_align & (req.req_align - 13'd1)) != '0);
    assign eff_mask  = (req.req_align > 13'(HEADER_BYTES)) ?
                       (req.req_align - 13'd1) : 13'(HEADER_BYTES - 1);

    // Unaligned data address and the padding that aligns it.
    assign unal = {1'b0, base_reg} + 33'(top_reg) + HDR_33;
    assign pad  = ((~unal[ALIGN_W-1:0]) + 13'd1) & eff_mask;

    // Header entry of an address being freed.
    assign lo       = {1'b0, base_reg} + HDR_33;
    assign addr_ext = {1'b0, req.free_address};
    assign hoff     = addr_ext - lo;
    assign free_ok  = (req.free_address != '0) && (addr_ext >= lo) && (hoff < ARENA_33);
    assign ram_raddr = hoff[HDR_SHIFT +: IW];

    // Final address, footprint and room check.
    assign data_addr = unal_reg + 33'(pad_reg);
    assign total     = 18'(HEADER_BYTES) + 18'(pad_reg) + 18'(size_reg);
    assign room_bad  = top_over_reg || data_addr[32] || (total > {1'b0, room_left_reg});

    always_comb
    begin
        if (align_bad_reg)
        begin
            alloc_status = ST_ALIGN;
        end
        else if (size_reg == '0)
        begin
            alloc_status = ST_SIZE;
        end
        else if (room_bad)
        begin
            alloc_status = ST_ROOM;
        end
        else
        begin
            alloc_status = ST_OK;
        end
    end

    // The header sits at offset top + pad from the base.
    assign hdr_off   = HW'(top_reg) + HW'(pad_reg);
    assign ram_waddr = hdr_off[HDR_SHIFT +: IW];
    assign ram_we    = ctrl.finish && (mode_reg == MODE_ALLOC) && (alloc_status == ST_OK);

    // Response and next top offset.
    always_comb
    begin
        top_next              = top_reg;
        rsp_next.status       = ST_OK;
        rsp_next.data_address = '0;
        case (mode_reg)
            MODE_ALLOC:
            begin
                rsp_next.status = alloc_status;
                if (alloc_status == ST_OK)
                begin
                    rsp_next.data_address = data_addr[ADDR_W-1:0];
                    top_next              = top_reg + total[TOP_W-1:0];
                end
            end
            MODE_FREE:
            begin
                if (free_ok_reg)
                begin
                    top_next = ram_rdata;
                end
            end
            MODE_CLEAR:
            begin
                top_next = '0;
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
        rsp_next.top_after = top_next;
    end

    // Header store.
    sac_ram #(
        .WIDTH (TOP_W),
        .DEPTH (HDR_DEPTH)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (top_reg),
        .re    (ctrl.load),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration and top offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            arena_reg <= 17'd65536;
            top_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else
                begin
                    arena_reg <= cfg_data[SIZE_W-1:0];
                end
            end
            if (ctrl.finish)
            begin
                top_reg <= top_next;
            end
        end
    end

    // Item registers and response register.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mode_reg      <= req.mode;
            size_reg      <= req.req_size;
            align_bad_reg <= align_bad;
            unal_reg      <= unal;
            pad_reg       <= pad;
            top_over_reg  <= (top_reg > lim);
            room_left_reg <= lim - top_reg;
            free_ok_reg   <= free_ok;
        end
        if (ctrl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hw/rtl/stack_allocator_aligned.sv =====
// Aligned LIFO stack allocator, top level: wires controller and datapath.
// Depends on sac_pkg, sac_ctrl, sac_datapath and sac_ram.
//
// A request is taken when start is high and busy is low; busy then stays
// high for one cycle while the request is finished. At the end of that
// cycle the response is registered onto rsp and marked by done, which is
// high for exactly one cycle. A new request can be accepted at the edge
// at which that response is taken; while busy is high none is taken. The
// two steps come from the header store: its read port is registered, so a
// free reads the header at the accept edge and restores the top offset at
// the next one; allocations use the same two steps for their address
// arithmetic. The receiver cannot stall the response, so it must sample rsp
// whenever done is high. The header store is not reset. Configuration
// may be written only while busy is low and no response is pending.
module stack_allocator_aligned
    import sac_pkg::*;
#(
    parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_t ctrl;

    // Sequencing.
    sac_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // Arithmetic, state and header store.
    sac_datapath #(
        .ARENA_BYTES (ARENA_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

// ===== dv/alloc_checker.sv =====
// Response checker for the aligned stack allocator: it predicts each response from the
// accepted requests and the register writes, and compares the responses in order.
// Depends on sac_pkg.
`timescale 1ns / 1ps

module alloc_checker
    import sac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  req_t             req,
    input  logic             done,
    input  rsp_t             rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               mismatches,
    output int               outstanding
);

    localparam int HDR_ENTRIES = ARENA_BYTES_DEF / HEADER_BYTES;
    localparam int SHOWN_MAX   = 10;

    // Local copy of the allocator state and its registers.
    logic [ADDR_W-1:0] base_mdl;
    logic [TOP_W-1:0]  arena_mdl;
    logic [TOP_W-1:0]  top_mdl;
    logic [TOP_W-1:0]  hdr_mdl [HDR_ENTRIES];

    // Responses that are due, oldest first.
    rsp_t              responses_due [$];
    rsp_t              want;

    // Applies one request to the local state and returns the response it must give.
    function automatic rsp_t next_response(req_t r);
        logic [63:0] lim;
        logic [63:0] align;
        logic [63:0] eff;
        logic [63:0] unal;
        logic [63:0] pad;
        logic [63:0] data;
        logic [63:0] total;
        logic [63:0] slot;
        logic [63:0] lo;
        logic [63:0] addr;
        rsp_t        o;

        o   = '0;
        lim = (arena_mdl < ARENA_BYTES_DEF) ? 64'(arena_mdl) : 64'(ARENA_BYTES_DEF);
        case (r.mode)
            MODE_ALLOC:
            begin
                align = 64'(r.req_align);
                // Alignment is checked before the size, and the size before the room.
                if (align == 0 || (align & (align - 1)) != 0)
                    o.status = ST_ALIGN;
                else if (r.req_size == 0)
                    o.status = ST_SIZE;
                else if (64'(top_mdl) > lim)
                    o.status = ST_ROOM;
                else
                begin
                    eff   = (align > HEADER_BYTES) ? align : 64'(HEADER_BYTES);
                    unal  = 64'(base_mdl) + 64'(top_mdl) + HEADER_BYTES;
                    pad   = (eff - unal % eff) % eff;
                    data  = unal + pad;
                    total = HEADER_BYTES + pad + 64'(r.req_size);
                    if (total > lim - 64'(top_mdl) || data > 64'hFFFF_FFFF)
                        o.status = ST_ROOM;
                    else
                    begin
                        // The header in front of the data keeps the previous top.
                        slot = ((data - HEADER_BYTES - 64'(base_mdl)) / HEADER_BYTES)
                               % HDR_ENTRIES;
                        hdr_mdl[slot]  = top_mdl;
                        top_mdl        = TOP_W'(64'(top_mdl) + total);
                        o.data_address = data[ADDR_W-1:0];
                    end
                end
            end
            MODE_FREE:
            begin
                // Null and out-of-arena addresses leave the top where it is.
                lo   = 64'(base_mdl) + HEADER_BYTES;
                addr = 64'(r.free_address);
                if (addr != 0 && addr >= lo && addr - lo < ARENA_BYTES_DEF)
                    top_mdl = hdr_mdl[((addr - lo) / HEADER_BYTES) % HDR_ENTRIES];
            end
            MODE_CLEAR:
            begin
                top_mdl = '0;
            end
            default:
            begin
            end
        endcase
        o.top_after = top_mdl;
        return o;
    endfunction

    // Responses are compared before the request of the same edge is predicted;
    // a response never belongs to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mdl    = '0;
            arena_mdl   = TOP_W'(ARENA_BYTES_DEF);
            top_mdl     = '0;
            responses_due.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (responses_due.size() == 0)
                begin
                    if (mismatches < SHOWN_MAX)
                        $display("%0t: response beat with none due: status %0d address %h top %0d",
                                 $time, rsp.status, rsp.data_address, rsp.top_after);
                    mismatches++;
                end
                else
                begin
                    want = responses_due.pop_front();
                    if (rsp.status !== want.status || rsp.data_address !== want.data_address
                        || rsp.top_after !== want.top_after)
                    begin
                        if (mismatches < SHOWN_MAX)
                            $display("%0t: expected status %0d address %h top %0d, got %0d %h %0d",
                                     $time, want.status, want.data_address, want.top_after,
                                     rsp.status, rsp.data_address, rsp.top_after);
                        mismatches++;
                    end
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == CFG_BASE)
                    base_mdl = cfg_data[ADDR_W-1:0];
                else
                    arena_mdl = cfg_data[TOP_W-1:0];
            end

            if (start && !busy)
                responses_due.push_back(next_response(req));
            outstanding = responses_due.size();
        end
    end

endmodule

// ===== dv/stack_allocator_aligned_tb.sv =====
// Testbench top for the aligned stack allocator: drives requests and register writes,
// and reports the verdict from the response checker.
// Depends on sac_pkg, stack_allocator_aligned and alloc_checker.
`timescale 1ns / 1ps

module stack_allocator_aligned_tb;
    import sac_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HDR_ENTRIES = ARENA_BYTES_DEF / HEADER_BYTES;
    localparam int         NUM_PHASES  = 6;
    // The fourth mode code is unused and must leave the state alone.
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Arena settings of the random phases, extremes included.
    localparam logic [ADDR_W-1:0] PHASE_BASE [NUM_PHASES] =
        '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h8765_4321, 32'hFFFF_FFFF,
          32'h0000_1000};
    localparam logic [TOP_W-1:0] PHASE_ARENA [NUM_PHASES] =
        '{17'd65536, 17'd4096, 17'd65536, 17'd65535, 17'd0, 17'd8192};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{150, 150, 150, 150, 50, 150};

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               mismatches;
    int               outstanding;
    int               cycle_cnt;

    // What the request generator knows: the base in force, which header entries hold
    // a value, and the blocks handed out, newest last.
    logic [ADDR_W-1:0] cur_base;
    bit                hdr_written [HDR_ENTRIES];
    logic [ADDR_W-1:0] live_blocks [$];

    stack_allocator_aligned u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    alloc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Header entry that belongs to a data address under the current base.
    function automatic int slot_of(logic [ADDR_W-1:0] addr);
        return int'(((64'(addr) - 64'(cur_base) - HEADER_BYTES) / HEADER_BYTES) % HDR_ENTRIES);
    endfunction

    // A successful allocation writes its header entry and hands out a block.
    always @(posedge clk)
    begin
        if (rst_n && done && rsp.status == ST_OK && rsp.data_address != 0)
        begin
            hdr_written[slot_of(rsp.data_address)] = 1'b1;
            live_blocks.push_back(rsp.data_address);
        end
    end

    // A free may only reach a header entry that has been written.
    function automatic bit free_is_safe(logic [ADDR_W-1:0] addr);
        logic [63:0] lo;

        lo = 64'(cur_base) + HEADER_BYTES;
        if (addr == 0 || 64'(addr) < lo || 64'(addr) - lo >= ARENA_BYTES_DEF)
            return 1'b1;
        return hdr_written[slot_of(addr)];
    endfunction

    // Mostly frees the newest block, sometimes an older one, a null, a stray address or
    // an address inside a written header slot.
    function automatic logic [ADDR_W-1:0] pick_free_address();
        logic [63:0] addr;
        int          roll;
        int          k;

        roll = $urandom_range(0, 99);
        if (live_blocks.size() != 0 && roll < 55)
            addr = live_blocks[$];
        else if (live_blocks.size() != 0 && roll < 75)
            addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        else if (roll < 82)
            addr = 0;
        else if (roll < 90)
            addr = $urandom;
        else
        begin
            k    = $urandom_range(0, HDR_ENTRIES - 1);
            addr = 64'(cur_base) + HEADER_BYTES + 64'(8 * k) + $urandom_range(0, 7);
        end
        if (addr > 64'hFFFF_FFFF || !free_is_safe(addr[ADDR_W-1:0]))
            addr = 0;

        // Freeing a block also releases every block above it.
        for (k = 0; k < live_blocks.size(); k++)
        begin
            if (live_blocks[k] == addr[ADDR_W-1:0])
            begin
                while (live_blocks.size() > k)
                    void'(live_blocks.pop_back());
                break;
            end
        end
        return addr[ADDR_W-1:0];
    endfunction

    function automatic req_t make_req(logic [1:0] mode, logic [SIZE_W-1:0] size,
                                      logic [ALIGN_W-1:0] align, logic [ADDR_W-1:0] addr);
        req_t r;

        r.mode         = mode;
        r.req_size     = size;
        r.req_align    = align;
        r.free_address = addr;
        return r;
    endfunction

    // Random request: mostly well-formed allocations and LIFO frees, with clears,
    // the unused mode and raw allocation noise mixed in.
    function automatic req_t random_req();
        req_t r;
        int   roll;
        int   pick;

        r = make_req(MODE_ALLOC, SIZE_W'($urandom_range(0, 65536)),
                     ALIGN_W'($urandom_range(0, 4096)), $urandom);
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                r.req_size = SIZE_W'($urandom_range(1, 128));
            else if (pick < 88)
                r.req_size = SIZE_W'($urandom_range(129, 4096));
            else if (pick < 96)
                r.req_size = SIZE_W'($urandom_range(4097, 65536));
            else
                r.req_size = '0;
            pick = $urandom_range(0, 99);
            if (pick < 88)
                r.req_align = ALIGN_W'(1) << $urandom_range(0, 12);
            else if (pick < 94)
                r.req_align = '0;
        end
        else if (roll < 85)
        begin
            r.mode         = MODE_FREE;
            r.free_address = pick_free_address();
        end
        else if (roll < 90)
            r.mode = MODE_CLEAR;
        else if (roll < 94)
            r.mode = MODE_NONE;
        return r;
    endfunction

    // One request beat: held until the block takes it.
    task automatic send_req(input req_t r);
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Waits until every response has arrived and the block is quiet.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes both arena registers once the block is idle.
    task automatic set_arena(input logic [ADDR_W-1:0] base, input logic [TOP_W-1:0] size);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_data  <= base;
        @(negedge clk);
        cfg_index <= CFG_SIZE;
        cfg_data  <= CFG_W'(size);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (base != cur_base)
            live_blocks.delete();
        cur_base = base;
    endtask

    initial
    begin
        int burst_left;

        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_BASE;
        cfg_data  = '0;
        cur_base  = '0;
        rst_n     = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: field extremes, every status and every mode.
        set_arena(32'h0000_0000, 17'd65536);
        send_req(make_req(MODE_ALLOC, 17'd1, 13'd1, '1));
        send_req(make_req(MODE_ALLOC, 17'd16, 13'd4096, '0));
        // Zero alignment and zero size together: the alignment is reported.
        send_req(make_req(MODE_ALLOC, 17'd0, 13'd0, 32'h5555_5555));
        send_req(make_req(MODE_ALLOC, 17'd5, 13'd3, '0));
        send_req(make_req(MODE_ALLOC, 17'd0, 13'd8, '0));
        // The size alone is larger than the room left in the arena.
        send_req(make_req(MODE_ALLOC, 17'd65536, 13'd8, '0));
        send_req(make_req(MODE_NONE, 17'd65536, 13'd4096, '1));
        send_req(make_req(MODE_FREE, '0, '0, '0));
        send_req(make_req(MODE_FREE, '0, '0, 32'd4));
        send_req(make_req(MODE_FREE, '0, '0, 32'h0001_0008));
        send_req(make_req(MODE_FREE, '0, '0, '1));
        settle();
        send_req(make_req(MODE_FREE, '0, '0, live_blocks.pop_back()));
        send_req(make_req(MODE_CLEAR, '0, '0, '0));
        // Exact fill, then nothing fits.
        send_req(make_req(MODE_ALLOC, 17'd65528, 13'd8, '0));
        send_req(make_req(MODE_ALLOC, 17'd1, 13'd1, '0));
        send_req(make_req(MODE_CLEAR, '0, '0, '0));
        // Shrinking the arena below the top refuses every allocation.
        send_req(make_req(MODE_ALLOC, 17'd1000, 13'd1, '0));
        set_arena(32'h0000_0000, 17'd512);
        send_req(make_req(MODE_ALLOC, 17'd1, 13'd1, '0));
        send_req(make_req(MODE_CLEAR, '0, '0, '0));
        // Near the top of the address space the padded data address overflows.
        set_arena(32'hFFFF_F000, 17'd65536);
        send_req(make_req(MODE_ALLOC, 17'd100, 13'd8, '0));
        send_req(make_req(MODE_ALLOC, 17'd16, 13'd4096, '0));
        send_req(make_req(MODE_CLEAR, '0, '0, '0));

        // Random phases, sent in bursts with random gaps.
        burst_left = 0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_arena(PHASE_BASE[p], PHASE_ARENA[p]);
            if ($urandom_range(0, 1) == 1)
                send_req(make_req(MODE_CLEAR, '0, '0, '0));
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                if (burst_left == 0)
                begin
                    idle_cycles($urandom_range(1, 8));
                    burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
                end
                burst_left--;
                send_req(random_req());
            end
        end

        settle();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
